FILE: rtl/kdf_pkg.sv
`default_nettype none

package kdf_pkg;

    // KISS special bytes
    localparam logic [7:0] CHR_FEND  = 8'hC0;
    localparam logic [7:0] CHR_FESC  = 8'hDB;
    localparam logic [7:0] CHR_TFEND = 8'hDC;
    localparam logic [7:0] CHR_TFESC = 8'hDD;

    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // configuration register indexes
    localparam logic CFG_FRAME_LIMIT  = 1'b0;
    localparam logic CFG_DATA_COMMAND = 1'b1;

    localparam logic [6:0] FRAME_LIMIT_RESET  = 7'd64;
    localparam logic [3:0] DATA_COMMAND_RESET = 4'd0;

    // running error counters, shared by decoder and drain
    typedef struct packed {
        logic [31:0] oversized;
        logic [31:0] malformed;
    } err_cnt_t;

    // drain engine states
    typedef enum logic [1:0] {
        DRN_IDLE,
        DRN_WAIT,
        DRN_SHOW
    } drain_state_t;

endpackage

`default_nettype wire

FILE: rtl/kdf_job_fifo.sv
`default_nettype none

module kdf_job_fifo
    import kdf_pkg::*;
#(
    parameter int LEN_W = 7
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [LEN_W-1:0] push_len,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic                  not_full,
    output logic [LEN_W-1:0]      head_len
);

    logic [LEN_W-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign not_empty = (count_reg != 2'd0);
    assign not_full  = (count_reg != 2'd2);
    assign head_len  = slot_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_len;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/kdf_decoder.sv
`default_nettype none

module kdf_decoder
    import kdf_pkg::*;
#(
    parameter int CAP   = 64,
    parameter int LEN_W = 7,
    parameter int AW    = 6
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [6:0]       cfg_wdata,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,
    input  wire logic             store_busy,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output logic [7:0]            wr_data,
    output logic                  job_push,
    output logic [LEN_W-1:0]      job_len,
    output err_cnt_t              err_cnt
);

    localparam int CW = (LEN_W > 7) ? LEN_W : 7;
    localparam logic [CW-1:0] CAP_C = CW'(CAP);

    logic [6:0]       limit_reg;
    logic [3:0]       dcmd_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             sync_reg, sync_next;
    logic             cmd_seen_reg, cmd_seen_next;
    logic [3:0]       cmd_nib_reg, cmd_nib_next;
    logic             esc_reg, esc_next;
    logic             drop_reg, drop_next;
    err_cnt_t         cnt_reg, cnt_next;
    logic             accept;
    logic [CW-1:0]    lim_w, lim_act;
    logic [7:0]       pay_byte;

    assign s_tready = !store_busy;
    assign accept   = s_tvalid && s_tready;
    assign err_cnt  = cnt_reg;
    assign job_len  = len_reg;
    assign wr_addr  = len_reg[AW-1:0];
    assign wr_data  = pay_byte;

    // limit in use, clamped to the store depth
    assign lim_w   = CW'(limit_reg);
    assign lim_act = (lim_w > CAP_C) ? CAP_C : lim_w;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= FRAME_LIMIT_RESET;
            dcmd_reg  <= DATA_COMMAND_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FRAME_LIMIT:  limit_reg <= cfg_wdata;
                CFG_DATA_COMMAND: dcmd_reg  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // byte classification and framing state
    always_comb begin
        len_next      = len_reg;
        sync_next     = sync_reg;
        cmd_seen_next = cmd_seen_reg;
        cmd_nib_next  = cmd_nib_reg;
        esc_next      = esc_reg;
        drop_next     = drop_reg;
        cnt_next      = cnt_reg;
        wr_en         = 1'b0;
        job_push      = 1'b0;
        pay_byte      = s_tdata;

        if (accept) begin
            if (s_tdata == CHR_FEND) begin
                // frame end: a pending escape spoils the frame
                if (esc_reg) begin
                    cnt_next.malformed = cnt_reg.malformed + 32'd1;
                end
                job_push = sync_reg && cmd_seen_reg && !drop_reg && !esc_reg &&
                           ((cmd_nib_reg & NIBBLE_MASK) == (dcmd_reg & NIBBLE_MASK));
                len_next      = '0;
                sync_next     = 1'b1;
                cmd_seen_next = 1'b0;
                esc_next      = 1'b0;
                drop_next     = 1'b0;
            end else if (sync_reg && !drop_reg) begin
                if (!cmd_seen_reg) begin
                    cmd_nib_next  = s_tdata[3:0] & NIBBLE_MASK;
                    cmd_seen_next = 1'b1;
                end else if (esc_reg && s_tdata != CHR_TFEND && s_tdata != CHR_TFESC) begin
                    // bad escape
                    cnt_next.malformed = cnt_reg.malformed + 32'd1;
                    drop_next = 1'b1;
                    esc_next  = 1'b0;
                    len_next  = '0;
                end else if (!esc_reg && s_tdata == CHR_FESC) begin
                    esc_next = 1'b1;
                end else begin
                    if (esc_reg) begin
                        pay_byte = (s_tdata == CHR_TFEND) ? CHR_FEND : CHR_FESC;
                    end
                    esc_next = 1'b0;
                    if (CW'(len_reg) >= lim_act) begin
                        // overflow past the limit
                        cnt_next.oversized = cnt_reg.oversized + 32'd1;
                        drop_next = 1'b1;
                        len_next  = '0;
                    end else begin
                        wr_en    = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            sync_reg     <= 1'b0;
            cmd_seen_reg <= 1'b0;
            cmd_nib_reg  <= 4'd0;
            esc_reg      <= 1'b0;
            drop_reg     <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            len_reg      <= len_next;
            sync_reg     <= sync_next;
            cmd_seen_reg <= cmd_seen_next;
            cmd_nib_reg  <= cmd_nib_next;
            esc_reg      <= esc_next;
            drop_reg     <= drop_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/kdf_drain.sv
`default_nettype none

module kdf_drain
    import kdf_pkg::*;
#(
    parameter int CAP   = 64,
    parameter int LEN_W = 7,
    parameter int AW    = 6
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [7:0]       wr_data,
    input  wire logic             job_valid,
    input  wire logic [LEN_W-1:0] job_len,
    output logic                  job_pop,
    input  wire err_cnt_t         err_cnt,
    output logic                  busy,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [71:0]           m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);

    logic [7:0]       store [CAP];
    logic [7:0]       rd_data_reg;
    drain_state_t     state_reg, state_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             empty_reg, empty_next;
    logic             last_hit;

    // frame store: decoder writes, drain reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_addr] <= wr_data;
        end
        rd_data_reg <= store[idx_reg];
    end

    assign last_hit = ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);
    assign busy     = (state_reg != DRN_IDLE);
    assign m_tvalid = (state_reg == DRN_SHOW);
    assign m_tlast  = empty_reg || last_hit;
    assign m_tuser  = empty_reg;
    assign m_tdata  = {err_cnt.oversized, err_cnt.malformed,
                       (empty_reg ? 8'h00 : rd_data_reg)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DRN_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        len_reg   <= len_next;
        empty_reg <= empty_next;
    end

    // one read per byte, then hold until taken
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        empty_next = empty_reg;
        job_pop    = 1'b0;
        case (state_reg)
            DRN_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    len_next   = job_len;
                    idx_next   = '0;
                    empty_next = (job_len == '0);
                    state_next = (job_len == '0) ? DRN_SHOW : DRN_WAIT;
                end
            end
            DRN_WAIT: begin
                state_next = DRN_SHOW;
            end
            DRN_SHOW: begin
                if (m_tready) begin
                    if (empty_reg || last_hit) begin
                        state_next = DRN_IDLE;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = DRN_WAIT;
                    end
                end
            end
            default: begin
                state_next = DRN_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/kiss_deframer.sv
`default_nettype none

// Channel   Dir  Word contents (low bits first)
// s_        in   tdata[7:0] rx_byte
// m_        out  tdata[7:0] frame_byte, [39:8] malformed_total, [71:40] oversized_total;
//                tlast last_byte; tuser empty_frame
// cfg_      in   index 0 frame_limit (7 bits), index 1 data_command (4 bits)
//
// Bytes are taken one per cycle while no frame is draining.
// A delivering FEND stalls input until its last word is taken; the drain
// handles each payload byte as a registered store read, then output.
// aresetn is synchronous; the store is not cleared, only control state.
// m_ words hold steady under m_tready low; s_tready does not depend on m_tready.

module kiss_deframer
    import kdf_pkg::*;
#(
    parameter int FRAME_CAPACITY = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [7:0] frame_byte, [39:8] malformed, [71:40] oversized
    output logic             m_tlast,
    output logic             m_tuser    // [0] empty_frame
);

    localparam int LEN_W = $clog2(FRAME_CAPACITY + 1);
    localparam int AW    = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic             job_push, job_pop, job_valid, job_room;
    logic [LEN_W-1:0] push_len, head_len;
    err_cnt_t         err_cnt;
    logic             drain_busy;
    logic             store_busy;

    // store is owned by the drain while a job waits or runs
    assign store_busy = job_valid || drain_busy || !job_room;

    kdf_decoder #(
        .CAP   (FRAME_CAPACITY),
        .LEN_W (LEN_W),
        .AW    (AW)
    ) u_decoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .store_busy (store_busy),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .job_push   (job_push),
        .job_len    (push_len),
        .err_cnt    (err_cnt)
    );

    kdf_job_fifo #(
        .LEN_W (LEN_W)
    ) u_job_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_len  (push_len),
        .pop       (job_pop),
        .not_empty (job_valid),
        .not_full  (job_room),
        .head_len  (head_len)
    );

    kdf_drain #(
        .CAP   (FRAME_CAPACITY),
        .LEN_W (LEN_W),
        .AW    (AW)
    ) u_drain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_valid (job_valid),
        .job_len   (head_len),
        .job_pop   (job_pop),
        .err_cnt   (err_cnt),
        .busy      (drain_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import kdf_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 100;
    localparam int STEADY_ITEMS   = 40;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_ESCAPE,
        FLAW_FEND_IN_ESCAPE,
        FLAW_NOISE
    } frame_flaw_t;

    // one decoded word as it leaves the m_ side
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        empty;
        logic [31:0] malformed;
        logic [31:0] oversized;
    } frame_word_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_FRAME_LIMIT;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;          // [7:0] frame_byte, [39:8] malformed, [71:40] oversized
    logic        m_tlast;
    logic        m_tuser;          // [0] empty_frame

    kiss_deframer #(
        .FRAME_CAPACITY(CAPACITY)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    // decoder state mirrored by the testbench
    logic [7:0]  frame_mem [CAPACITY];
    int          frame_len      = 0;
    bit          synced         = 1'b0;
    bit          cmd_seen       = 1'b0;
    logic [3:0]  cmd_nib        = '0;
    bit          esc_pend       = 1'b0;
    bit          discarding     = 1'b0;
    logic [31:0] n_malformed    = '0;
    logic [31:0] n_oversized    = '0;
    logic [6:0]  cfg_limit      = FRAME_LIMIT_RESET;
    logic [3:0]  cfg_cmd        = DATA_COMMAND_RESET;

    frame_word_t pending_words[$];

    bit idle_on  = 1'b1;
    bit stall_on = 1'b1;

    int items_sent       = 0;
    int words_checked    = 0;
    int frames_delivered = 0;
    int empty_frames     = 0;
    int mismatch_count   = 0;
    int idle_cycles      = 0;

    function automatic int eff_limit();
        return (cfg_limit > CAPACITY) ? CAPACITY : int'(cfg_limit);
    endfunction

    // advance the mirrored decoder by one raw byte, queue any words it delivers
    function automatic void kiss_decode(input logic [7:0] b);
        logic [7:0]  v;
        frame_word_t w;
        v = b;
        if (b == CHR_FEND) begin
            if (esc_pend) begin
                n_malformed++;
                discarding = 1'b1;
            end
            if (synced && cmd_seen && !discarding && cmd_nib == cfg_cmd) begin
                if (frame_len == 0) begin
                    w = '{data: 8'h00, last: 1'b1, empty: 1'b1,
                          malformed: n_malformed, oversized: n_oversized};
                    pending_words.push_back(w);
                end else begin
                    for (int i = 0; i < frame_len; i++) begin
                        w = '{data: frame_mem[i], last: (i == frame_len - 1), empty: 1'b0,
                              malformed: n_malformed, oversized: n_oversized};
                        pending_words.push_back(w);
                    end
                end
            end
            frame_len  = 0;
            synced     = 1'b1;
            cmd_seen   = 1'b0;
            esc_pend   = 1'b0;
            discarding = 1'b0;
            return;
        end
        if (!synced || discarding)
            return;
        if (!cmd_seen) begin
            cmd_nib  = b[3:0];
            cmd_seen = 1'b1;
            return;
        end
        if (esc_pend) begin
            if (b == CHR_TFEND) begin
                v = CHR_FEND;
            end else if (b == CHR_TFESC) begin
                v = CHR_FESC;
            end else begin
                // bad escape drops the frame
                n_malformed++;
                discarding = 1'b1;
                esc_pend   = 1'b0;
                frame_len  = 0;
                return;
            end
            esc_pend = 1'b0;
        end else if (b == CHR_FESC) begin
            esc_pend = 1'b1;
            return;
        end
        if (frame_len >= eff_limit()) begin
            n_oversized++;
            discarding = 1'b1;
            frame_len  = 0;
            esc_pend   = 1'b0;
            return;
        end
        frame_mem[frame_len] = v;
        frame_len++;
    endfunction

    // send one raw byte, with an optional gap ahead of it
    task automatic send_word(input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        kiss_decode(b);
    endtask

    // hold input off until every queued word has been taken and the drain has settled
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_FRAME_LIMIT)
            cfg_limit = val;
        else
            cfg_cmd = val[3:0];
    endtask

    task automatic set_config(input logic [6:0] limit, input logic [3:0] cmd);
        logic [2:0] junk;
        junk = 3'($urandom_range(0, 7));
        write_reg(CFG_FRAME_LIMIT, limit);
        // upper bits of the data command write are don't-care
        write_reg(CFG_DATA_COMMAND, {junk, cmd});
    endtask

    // command byte with a random high nibble, never a frame delimiter
    function automatic logic [7:0] make_command(input logic [3:0] nib);
        logic [7:0] b;
        b = {4'($urandom_range(0, 15)), nib};
        if (b == CHR_FEND)
            b = {4'h0, nib};
        return b;
    endfunction

    // one frame after a leading FEND: command, escaped payload, closing FEND
    task automatic send_frame(input logic [7:0] cmd_byte, input int len,
                              input frame_flaw_t flaw);
        int         flaw_at;
        logic [7:0] b;
        flaw_at = (len > 0) ? $urandom_range(0, len - 1) : 0;
        send_word(cmd_byte);
        for (int k = 0; k < len; k++) begin
            if (flaw == FLAW_BAD_ESCAPE && k == flaw_at) begin
                send_word(CHR_FESC);
                do b = 8'($urandom);
                while (b == CHR_TFEND || b == CHR_TFESC || b == CHR_FEND);
                send_word(b);
            end
            if (flaw == FLAW_NOISE && k == flaw_at)
                send_word(8'($urandom));
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: b = CHR_FEND;
                    1: b = CHR_FESC;
                    2: b = CHR_TFEND;
                    default: b = CHR_TFESC;
                endcase
            end else begin
                b = 8'($urandom);
            end
            if (b == CHR_FEND) begin
                send_word(CHR_FESC);
                send_word(CHR_TFEND);
            end else if (b == CHR_FESC) begin
                send_word(CHR_FESC);
                send_word(CHR_TFESC);
            end else begin
                send_word(b);
            end
        end
        if (flaw == FLAW_FEND_IN_ESCAPE || (flaw == FLAW_BAD_ESCAPE && len == 0))
            send_word(CHR_FESC);
        send_word(CHR_FEND);
    endtask

    function automatic int pick_length();
        int lim;
        lim = eff_limit();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return (lim == 0) ? $urandom_range(0, 1) : lim - 1 + $urandom_range(0, 2);
            2: return $urandom_range(9, CAPACITY + 1);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic frame_flaw_t pick_flaw();
        case ($urandom_range(0, 19))
            0: return FLAW_BAD_ESCAPE;
            1: return FLAW_FEND_IN_ESCAPE;
            2: return FLAW_NOISE;
            default: return FLAW_NONE;
        endcase
    endfunction

    // hand-picked sequences, starting out of sync right after reset
    task automatic test_directed();
        // ignored before sync
        send_word(8'h00);
        send_word(8'hFF);
        send_word(CHR_FEND);
        // empty data frame
        send_word(8'h00);
        send_word(CHR_FEND);
        // data frame with extremes, both escapes and a bare TFEND byte
        send_word(8'hF0);
        send_word(8'h00);
        send_word(8'hFF);
        send_word(CHR_FESC);
        send_word(CHR_TFEND);
        send_word(CHR_FESC);
        send_word(CHR_TFESC);
        send_word(CHR_TFEND);
        send_word(CHR_FEND);
        // bad escape, rest of frame dropped
        send_word(8'h00);
        send_word(CHR_FESC);
        send_word(8'h41);
        send_word(8'h55);
        send_word(CHR_FEND);
        // delimiter while an escape is pending
        send_word(8'h00);
        send_word(CHR_FESC);
        send_word(CHR_FEND);
        // escape byte taken as command, nibble B is not a data frame
        send_word(CHR_FESC);
        send_word(8'h12);
        send_word(CHR_FEND);
    endtask

    // limit and command at their extremes, frames right at and past the limit
    task automatic test_limits();
        logic [6:0] limits [4] = '{7'd1, 7'd0, 7'd127, 7'd5};
        logic [3:0] cmds   [4] = '{4'hF, 4'h5, 4'h0, 4'hA};
        int lim;
        for (int p = 0; p < 4; p++) begin
            set_config(limits[p], cmds[p]);
            lim = eff_limit();
            send_frame(make_command(cfg_cmd), lim, FLAW_NONE);
            send_frame(make_command(cfg_cmd), lim + 1, FLAW_NONE);
            send_frame(make_command(cfg_cmd), 0, FLAW_NONE);
            send_frame(make_command(~cfg_cmd), 2, FLAW_NONE);
        end
    endtask

    // the sender stops after each frame until all its words have come out
    task automatic test_drain_pause();
        set_config(7'd16, 4'h3);
        for (int f = 0; f < 4; f++) begin
            send_frame(make_command(cfg_cmd), $urandom_range(1, 16), FLAW_NONE);
            wait_drained();
        end
    endtask

    // random frames under random settings, mostly well formed
    task automatic test_random(input int n_items);
        int stop_at;
        logic [6:0] limit;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 5))
                0: limit = 7'd0;
                1: limit = 7'd127;
                2: limit = 7'd64;
                default: limit = 7'($urandom_range(1, 12));
            endcase
            set_config(limit, 4'($urandom_range(0, 15)));
            for (int f = 0; f < 8 && items_sent < stop_at; f++) begin
                if ($urandom_range(0, 3) == 0)
                    send_frame(make_command(4'($urandom_range(0, 15))), pick_length(),
                               pick_flaw());
                else
                    send_frame(make_command(cfg_cmd), pick_length(), pick_flaw());
            end
        end
    endtask

    // receiver side back-pressure in random bursts
    initial begin : rx_stall
        int n;
        forever begin
            @(posedge aclk);
            if (stall_on && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic report_word(input string what, input frame_word_t want,
                               input frame_word_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t %s: expected byte %02h last %0b empty %0b mal %0d ovr %0d",
                     $realtime, what, want.data, want.last, want.empty, want.malformed,
                     want.oversized);
            $display("    got byte %02h last %0b empty %0b mal %0d ovr %0d",
                     got.data, got.last, got.empty, got.malformed, got.oversized);
        end
    endtask

    // compare every taken word with the oldest queued one
    always @(posedge aclk) begin : check_words
        frame_word_t want;
        frame_word_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{data: m_tdata[7:0], last: m_tlast, empty: m_tuser,
                    malformed: m_tdata[39:8], oversized: m_tdata[71:40]};
            words_checked++;
            if (got.last)
                frames_delivered++;
            if (got.empty)
                empty_frames++;
            if (pending_words.size() == 0) begin
                report_word("unexpected word", '0, got);
            end else begin
                want = pending_words.pop_front();
                if (got.data !== want.data || got.last !== want.last ||
                    got.empty !== want.empty || got.malformed !== want.malformed ||
                    got.oversized !== want.oversized)
                    report_word("word mismatch", want, got);
            end
        end
    end

    // no progress on any port for too long
    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t no progress for %0d cycles", $realtime, idle_cycles);
                $display("kiss_deframer: mismatch");
                $finish;
            end
        end
    end

    initial begin : run
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_limits();
        test_drain_pause();
        test_random(RANDOM_ITEMS);

        // closing stretch without any idling
        idle_on  = 1'b0;
        stall_on = 1'b0;
        test_random(STEADY_ITEMS);

        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (4 * SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes, checked %0d words in %0d delivered frames (%0d empty).",
                 items_sent, words_checked, frames_delivered, empty_frames);
        $display("Decoder saw %0d malformed and %0d oversized frames; %0d mismatches.",
                 n_malformed, n_oversized, mismatch_count);
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("kiss_deframer: match");
        else
            $display("kiss_deframer: mismatch");
        $finish;
    end

endmodule
